### hdl/gwws_pkg.sv
package gwws_pkg;

  localparam logic [7:0]  CH_NL       = 8'd10;
  localparam logic [7:0]  CH_SP       = 8'd32;
  localparam logic [7:0]  CH_NUL      = 8'd0;
  localparam logic [15:0] WIDTH_RESET = 16'd100;
  localparam int          LINE_W      = 16;

endpackage

### hdl/gwws_store.sv
module gwws_store #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a byte written this cycle is seen by a read of the same entry
  always_ff @(posedge clk) begin
    if (wen && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/greedy_word_wrap_stream.sv
// Greedy word wrap for a byte stream.
// Input: one character per request on s_axis (tdata = data_byte). A request
// with tlast high is end of input: its data is ignored, the held word is
// flushed and a newline follows. Zero bytes are dropped.
// Output: one character per request on m_axis; tlast marks the final byte
// caused by one input request. Inserted line breaks are byte 10.
// cfg_wen/cfg_wdata set the line width; write it only while the block is idle.
// Timing: a byte that only joins the word is taken and the block stays in
// IDLE. A space, newline, full word or end of input starts an emit sequence
// of N bytes (word plus inserted newlines); the word store is read one entry
// per cycle through its registered read port while m_axis_tready allows,
// and s_axis_tready is low until the sequence ends. The accepted request is
// registered into the state register, then the first byte into out_data.
// When m_axis_tready is low the output register holds its byte and the emit
// sequence waits; nothing is lost.
// Reset clears word and line lengths and sets the width to 100. The word
// store needs no clearing: only entries written for the current word are read.
module greedy_word_wrap_stream
  import gwws_pkg::*;
#(
  parameter int WORD_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // last_of_run
);

  localparam int AW = $clog2(WORD_MAX);
  localparam int LW = $clog2(WORD_MAX + 1);

  typedef enum logic [1:0] {IDLE, PRE_NL, WORD, POST_NL} state_t;

  state_t              state, state_next;
  logic [15:0]         line_width;
  logic [LINE_W-1:0]   line_length, line_length_next;
  logic [LW-1:0]       word_length, word_length_next;
  logic [LW-1:0]       cnt, cnt_next;
  logic [AW-1:0]       idx, idx_next;
  logic                post_nl, post_nl_next;
  logic                out_valid, out_valid_next;
  logic [7:0]          out_data, out_data_next;
  logic                out_last, out_last_next;

  logic                accept, eoi, is_delim, full, wrap, out_free, word_end;
  logic [LW-1:0]       wl_inc;
  logic [LINE_W+1:0]   wrap_sum;
  logic [LINE_W:0]     sat_sum;
  logic [LINE_W-1:0]   sat_line;
  logic                st_wen;
  logic [7:0]          rd_data;

  gwws_store #(.DEPTH(WORD_MAX)) u_store (
    .clk   (clk),
    .wen   (st_wen),
    .waddr (word_length[AW-1:0]),
    .wdata (s_axis_tdata),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  assign s_axis_tready = (state == IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eoi           = s_axis_tlast;
  assign is_delim      = (s_axis_tdata == CH_SP) || (s_axis_tdata == CH_NL);
  assign wl_inc        = word_length + LW'(1);
  assign full          = (wl_inc == LW'(WORD_MAX));
  assign wrap_sum      = (LINE_W+2)'(line_length) + (LINE_W+2)'(wl_inc) + (LINE_W+2)'(1);
  assign wrap          = wrap_sum > (LINE_W+2)'(line_width);
  assign sat_sum       = (LINE_W+1)'(line_length) + (LINE_W+1)'(wl_inc);
  assign sat_line      = sat_sum[LINE_W] ? '1 : sat_sum[LINE_W-1:0];
  assign st_wen        = accept && !eoi && (s_axis_tdata != CH_NUL);
  assign out_free      = !out_valid || m_axis_tready;
  assign word_end      = ({{(LW-AW){1'b0}}, idx} == cnt - LW'(1));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  always_comb begin
    state_next       = state;
    line_length_next = line_length;
    word_length_next = word_length;
    cnt_next         = cnt;
    idx_next         = idx;
    post_nl_next     = post_nl;
    out_valid_next   = out_valid && !m_axis_tready;
    out_data_next    = out_data;
    out_last_next    = out_last;
    case (state)
      IDLE: begin
        idx_next = '0;
        if (accept) begin
          if (eoi) begin
            cnt_next         = word_length;
            post_nl_next     = 1'b1;
            word_length_next = '0;
            line_length_next = '0;
            state_next       = (word_length == '0) ? POST_NL : WORD;
          end else if (s_axis_tdata != CH_NUL) begin
            post_nl_next = 1'b0;
            cnt_next     = wl_inc;
            if (is_delim) begin
              word_length_next = '0;
              if (s_axis_tdata == CH_NL) begin
                line_length_next = '0;
              end else if (wrap) begin
                line_length_next = LINE_W'(wl_inc);
              end else begin
                line_length_next = sat_line;
              end
              state_next = wrap ? PRE_NL : WORD;
            end else if (full) begin
              word_length_next = '0;
              line_length_next = sat_line;
              state_next       = WORD;
            end else begin
              word_length_next = wl_inc;
            end
          end
        end
      end
      PRE_NL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = CH_NL;
          out_last_next  = 1'b0;
          state_next     = WORD;
        end
      end
      WORD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = rd_data;
          out_last_next  = word_end && !post_nl;
          if (word_end) begin
            idx_next   = '0;
            state_next = post_nl ? POST_NL : IDLE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      POST_NL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = CH_NL;
          out_last_next  = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      line_width  <= WIDTH_RESET;
      line_length <= '0;
      word_length <= '0;
      cnt         <= '0;
      idx         <= '0;
      post_nl     <= 1'b0;
      out_valid   <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      state       <= state_next;
      line_length <= line_length_next;
      word_length <= word_length_next;
      cnt         <= cnt_next;
      idx         <= idx_next;
      post_nl     <= post_nl_next;
      out_valid   <= out_valid_next;
      out_last    <= out_last_next;
      if (cfg_wen) begin
        line_width <= cfg_wdata;
      end
    end
    out_data <= out_data_next;
  end

endmodule
